### hw/rtl/sau_pkg.sv
// Package for the stack arithmetic unit.
// Holds the operation, status and shift codes and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sau_pkg;

  localparam int unsigned DATA_W = 16;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_NEG  = 4'd3,
    OP_EQ   = 4'd4,
    OP_GT   = 4'd5,
    OP_LT   = 4'd6,
    OP_AND  = 4'd7,
    OP_OR   = 4'd8,
    OP_NOT  = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_PUSH = 2'd1,
    SH_POP1 = 2'd2,
    SH_POP2 = 2'd3
  } shift_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_t           status;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/stack_arithmetic_unit_top.sv
// Top level of the 16-bit stack arithmetic unit.
// Instantiates sau_alu and a chain of sau_cell entries; depends on sau_pkg.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  in_req_type, in_push_value
//   out_     output     out_valid / out_stall out_result_value, out_status
//
// One item is taken per cycle while in_stall is low; its result is registered in output or skid.
// The two top entries sit in the first two cells, so the operands are always at hand.
// A skid register holds one result while the output is stalled; input stalls only when it is full.
// Reset empties the stack and drops any pending results; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module stack_arithmetic_unit_top
  import sau_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256
)
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [3:0]        in_req_type,
  input  wire logic [DATA_W-1:0] in_push_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [DATA_W-1:0] out_result_value,
  output logic      [1:0]        out_status
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] DepthC = CNT_W'(STACK_DEPTH);

  logic [DATA_W-1:0] q [STACK_DEPTH];
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CNT_W-1:0]  alu_cnt;
  res_t              alu_res;
  shift_t            alu_shift;
  shift_t            shift;
  op_t               op;
  logic              in_fire;
  logic              out_fire;

  res_t out_res_r;
  res_t out_res_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  res_t skid_res_r;
  res_t skid_res_nxt;
  logic skid_valid_r;
  logic skid_valid_nxt;

  assign op       = op_t'(in_req_type);
  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  sau_alu #(
    .CNT_W       (CNT_W),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_alu (
    .op      (op),
    .x       (q[1]),
    .y       (q[0]),
    .cnt     (cnt_r),
    .res     (alu_res),
    .shift   (alu_shift),
    .cnt_nxt (alu_cnt)
  );

  assign shift   = in_fire ? alu_shift : SH_HOLD;
  assign cnt_nxt = in_fire ? alu_cnt : cnt_r;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_chain
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] below1;
    logic [DATA_W-1:0] below2;

    if (i == 0) begin : g_top
      assign above = in_push_value;
    end else begin : g_mid
      assign above = q[i-1];
    end
    if (i + 1 < STACK_DEPTH) begin : g_b1
      assign below1 = q[i+1];
    end else begin : g_b1_end
      assign below1 = '0;
    end
    if (i + 2 < STACK_DEPTH) begin : g_b2
      assign below2 = q[i+2];
    end else begin : g_b2_end
      assign below2 = '0;
    end

    sau_cell u_cell (
      .clk    (clk),
      .shift  (shift),
      .above  (above),
      .below1 (below1),
      .below2 (below2),
      .q      (q[i])
    );
  end

  always_comb begin
    out_res_nxt    = out_res_r;
    out_valid_nxt  = out_valid_r;
    skid_res_nxt   = skid_res_r;
    skid_valid_nxt = skid_valid_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
      if (skid_valid_r) begin
        out_res_nxt    = skid_res_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end
    if (in_fire) begin
      if (out_valid_r && out_stall) begin
        skid_res_nxt   = alu_res;
        skid_valid_nxt = 1'b1;
      end else begin
        out_res_nxt   = alu_res;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r.value;
  assign out_status       = out_res_r.status;

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DepthC)
    else $error("stack count exceeds depth");

  a_push_count : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && op == OP_PUSH && cnt_r != DepthC) |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("push did not grow the stack by one");

  a_skid_order : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output is empty");

  a_over_push : assert property (@(posedge clk) disable iff (!rst_n)
    (alu_res.status == ST_OVER) |-> (op == OP_PUSH && cnt_r == DepthC))
    else $error("overflow reported outside a push on a full stack");

endmodule

`default_nettype wire

### hw/rtl/sau_cell.sv
// One stack entry of the shifting stack chain.
// Loads from the entry above on a push, or from one or two entries below on a pop.
// Depends on sau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sau_cell
  import sau_pkg::*;
(
  input  wire logic              clk,
  input  wire shift_t            shift,
  input  wire logic [DATA_W-1:0] above,
  input  wire logic [DATA_W-1:0] below1,
  input  wire logic [DATA_W-1:0] below2,
  output logic      [DATA_W-1:0] q
);

  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] q_nxt;

  always_comb begin
    case (shift)
      SH_PUSH: q_nxt = above;
      SH_POP1: q_nxt = below1;
      SH_POP2: q_nxt = below2;
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

### hw/rtl/sau_alu.sv
// Operation decode and arithmetic on the two top entries of the stack.
// Produces the result record, the shift command for the chain and the next count.
// Depends on sau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sau_alu
  import sau_pkg::*;
#(
  parameter int unsigned CNT_W = 9,
  parameter int unsigned STACK_DEPTH = 256
)
(
  input  wire op_t               op,
  input  wire logic [DATA_W-1:0] x,
  input  wire logic [DATA_W-1:0] y,
  input  wire logic [CNT_W-1:0]  cnt,
  output res_t                   res,
  output shift_t                 shift,
  output logic      [CNT_W-1:0]  cnt_nxt
);

  localparam logic [CNT_W-1:0] DepthC = CNT_W'(STACK_DEPTH);
  localparam logic [DATA_W-1:0] AllOnes = {DATA_W{1'b1}};

  always_comb begin
    res.value  = '0;
    res.status = ST_OK;
    shift      = SH_HOLD;
    cnt_nxt    = cnt;
    case (op)
      OP_PUSH: begin
        if (cnt == DepthC) begin
          res.status = ST_OVER;
        end else begin
          shift   = SH_PUSH;
          cnt_nxt = cnt + CNT_W'(1);
        end
      end
      OP_NEG, OP_NOT: begin
        if (cnt == '0) begin
          res.status = ST_UNDER;
        end else begin
          shift   = SH_POP1;
          cnt_nxt = cnt - CNT_W'(1);
          res.value = (op == OP_NEG) ? (DATA_W'(0) - y) : ~y;
        end
      end
      OP_ADD, OP_SUB, OP_EQ, OP_GT, OP_LT, OP_AND, OP_OR: begin
        if (cnt < CNT_W'(2)) begin
          res.status = ST_UNDER;
        end else begin
          shift   = SH_POP2;
          cnt_nxt = cnt - CNT_W'(2);
          case (op)
            OP_ADD:  res.value = x + y;
            OP_SUB:  res.value = x - y;
            OP_EQ:   res.value = (x == y) ? AllOnes : '0;
            OP_GT:   res.value = ($signed(x) > $signed(y)) ? AllOnes : '0;
            OP_LT:   res.value = ($signed(x) < $signed(y)) ? AllOnes : '0;
            OP_AND:  res.value = x & y;
            default: res.value = x | y;
          endcase
        end
      end
      default: begin
        res.value = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### verif/tb_stack_arithmetic_unit_top.sv
// Self-checking testbench for stack_arithmetic_unit_top, the 16-bit stack ALU.
// Keeps its own copy of the stack to predict every result; uses sau_pkg for codes and types.
// Runs directed and random transfers under three sender and receiver idling regimes.
`timescale 1ns / 1ps

module tb_stack_arithmetic_unit_top;
  import sau_pkg::*;

  localparam int unsigned STACK_DEPTH = 256;
  localparam logic [3:0] REQ_TYPE_MAX = 4'hF;
  localparam int MAX_REPORTS = 10;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [3:0]        in_req_type = OP_PUSH;
  logic [DATA_W-1:0] in_push_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_result_value;
  logic [1:0]        out_status;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned       depth = 0;
  logic [DATA_W-1:0] last_operand = '0;
  res_t              pending_results [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int results_checked = 0;
  int error_count = 0;
  int underflows_seen = 0;
  int overflows_seen = 0;
  int ignored_seen = 0;

  stack_arithmetic_unit_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_value(out_result_value),
    .out_status      (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_stack_arithmetic_unit_top: errors");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic res_t stack_step(logic [3:0] op, logic [DATA_W-1:0] val);
    res_t r;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    r.value = '0;
    r.status = ST_OK;
    if (op == OP_PUSH) begin
      if (depth >= STACK_DEPTH) begin
        r.status = ST_OVER;
      end else begin
        stack_mem[depth] = val;
        depth++;
      end
    end else if (op == OP_NEG || op == OP_NOT) begin
      if (depth < 1) begin
        r.status = ST_UNDER;
      end else begin
        y = stack_mem[depth - 1];
        depth--;
        r.value = (op == OP_NEG) ? DATA_W'(-y) : ~y;
      end
    end else if (op >= OP_ADD && op <= OP_OR) begin
      if (depth < 2) begin
        r.status = ST_UNDER;
      end else begin
        y = stack_mem[depth - 1];
        x = stack_mem[depth - 2];
        depth -= 2;
        case (op)
          OP_ADD: r.value = x + y;
          OP_SUB: r.value = x - y;
          OP_EQ:  r.value = (x == y) ? '1 : '0;
          OP_GT:  r.value = ($signed(x) > $signed(y)) ? '1 : '0;
          OP_LT:  r.value = ($signed(x) < $signed(y)) ? '1 : '0;
          OP_AND: r.value = x & y;
          default: r.value = x | y;
        endcase
      end
    end else begin
      ignored_seen++;
    end
    if (r.status == ST_UNDER) underflows_seen++;
    if (r.status == ST_OVER) overflows_seen++;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 16'h0001;
          2: v = 16'h7FFF;
          3: v = 16'h8000;
          default: v = '1;
        endcase
      end
      1: v = last_operand;
      default: v = DATA_W'($urandom_range(16'hFFFF));
    endcase
    last_operand = v;
    return v;
  endfunction

  task automatic send_item(input logic [3:0] op, input logic [DATA_W-1:0] val);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= op;
    in_push_value <= val;
    do begin
      @(negedge clk);
      stalled = (in_stall !== 1'b0);
      @(posedge clk);
    end while (stalled);
    pending_results.push_back(stack_step(op, val));
    items_sent++;
  endtask

  always @(negedge clk) begin
    res_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("Unexpected result transfer: value %h status %0d",
                   out_result_value, out_status);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_result_value !== want.value || out_status !== want.status) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("Result %0d mismatch: expected value %h status %0d, got value %h status %0d",
                     results_checked, want.value, want.status, out_result_value, out_status);
        end
      end
    end
  end

  task automatic test_stack_underflow();
    send_item(OP_ADD, 16'hFFFF);
    send_item(OP_NOT, 16'h0000);
    send_item(OP_PUSH, 16'h8000);
    send_item(OP_SUB, 16'h5555);
    send_item(OP_NEG, 16'hAAAA);
  endtask

  task automatic test_each_operation();
    send_item(OP_PUSH, 16'h7FFF);
    send_item(OP_PUSH, 16'h0001);
    send_item(OP_ADD, 16'h0000);
    send_item(OP_PUSH, 16'h8000);
    send_item(OP_PUSH, 16'h0001);
    send_item(OP_SUB, 16'h0000);
    send_item(OP_PUSH, 16'h8000);
    send_item(OP_PUSH, 16'h7FFF);
    send_item(OP_LT, 16'h0000);
    send_item(OP_PUSH, 16'h7FFF);
    send_item(OP_PUSH, 16'h8000);
    send_item(OP_GT, 16'h0000);
    send_item(OP_PUSH, 16'hFFFF);
    send_item(OP_PUSH, 16'hFFFF);
    send_item(OP_EQ, 16'h0000);
    send_item(OP_PUSH, 16'hF0F0);
    send_item(OP_PUSH, 16'h0FF0);
    send_item(OP_AND, 16'h0000);
    send_item(OP_PUSH, 16'hF0F0);
    send_item(OP_PUSH, 16'h0F0F);
    send_item(OP_OR, 16'h0000);
    send_item(OP_PUSH, 16'h0000);
    send_item(OP_NOT, 16'hFFFF);
  endtask

  task automatic test_ignored_codes();
    send_item(REQ_TYPE_MAX, 16'hFFFF);
  endtask

  task automatic test_full_stack();
    while (depth < STACK_DEPTH) send_item(OP_PUSH, pick_operand());
    send_item(OP_PUSH, 16'h8000);
    send_item(OP_PUSH, 16'h7FFF);
    while (depth > 0)
      send_item(4'($urandom_range(OP_NOT, OP_ADD)), DATA_W'($urandom_range(16'hFFFF)));
    send_item(OP_ADD, 16'h0000);
  endtask

  task automatic test_random_mix(input int count);
    int sent;
    int seg_len;
    int push_pct;
    int pick;
    sent = 0;
    while (sent < count) begin
      seg_len = $urandom_range(60, 20);
      case ($urandom_range(2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      repeat (seg_len) begin
        pick = $urandom_range(99);
        if (pick < 3)
          send_item(4'($urandom_range(REQ_TYPE_MAX, OP_NOT + 1)),
                    DATA_W'($urandom_range(16'hFFFF)));
        else if (pick < 3 + (push_pct * 97) / 100)
          send_item(OP_PUSH, pick_operand());
        else
          send_item(4'($urandom_range(OP_NOT, OP_ADD)), DATA_W'($urandom_range(16'hFFFF)));
        sent++;
      end
    end
  endtask

  initial begin
    int drain_cycles;
    send_idle_pct = 31;
    recv_stall_pct = 63;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_stack_underflow();
    test_each_operation();
    test_ignored_codes();
    test_random_mix(510);

    send_idle_pct = 63;
    recv_stall_pct = 31;
    test_full_stack();
    test_random_mix(510);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_mix(510);

    in_valid <= 1'b0;
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (pending_results.size() != 0) begin
      error_count += pending_results.size();
      $display("%0d expected results never arrived.", pending_results.size());
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d requests and checked %0d results under three idling regimes.",
             items_sent, results_checked);
    $display("Underflows %0d, overflows %0d, ignored request codes %0d, mismatches %0d.",
             underflows_seen, overflows_seen, ignored_seen, error_count);
    if (error_count == 0) begin
      $display("tb_stack_arithmetic_unit_top: clean");
    end else begin
      $display("tb_stack_arithmetic_unit_top: errors");
    end
    $finish;
  end

endmodule
